### rtl/core/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared constants, types and output-forming functions for the pcg generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

  // lcg constants
  localparam logic [63:0] LcgResetState = 64'h853c49e6748fea9b;
  localparam logic [63:0] LcgMul        = 64'd6364136223846793005;
  localparam logic [63:0] LcgSeedMul    = 64'd5291759402843659291;
  localparam logic [63:0] LcgInc        = 64'd1442695040888963407;

  // xorshift and rotate positions
  localparam int unsigned XshShift = 18;
  localparam int unsigned XshDrop  = 27;
  localparam int unsigned RotPos   = 59;

  // draw width codes, any other code acts as 64 bits
  localparam logic [1:0] WidthCode16 = 2'd0;
  localparam logic [1:0] WidthCode32 = 2'd1;

  // configuration port
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 64;
  localparam logic [0:0]  RegSeed  = 1'b0;

  // remainder unit counter, holds 0..64
  localparam int unsigned CntW = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_MUL_SUM,
    ST_MOD,
    ST_OUT
  } pcg_state_e;

  typedef enum logic [1:0] {
    MS_LL,
    MS_LH,
    MS_HL,
    MS_SUM
  } pcg_mul_step_e;

  typedef struct packed {
    logic          item_load;
    logic          seed_load;
    logic          seed_op;
    logic          mul_en;
    pcg_mul_step_e mul_step;
    logic          mod_init;
    logic          mod_iter;
    logic          out_load;
  } pcg_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic mod_done;
    logic out_free;
  } pcg_status_t;

  function automatic logic [63:0] width_mask(logic [1:0] code);
    logic [63:0] m;
    unique case (code)
      WidthCode16: m = 64'h0000_0000_0000_ffff;
      WidthCode32: m = 64'h0000_0000_ffff_ffff;
      default:     m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [CntW-1:0] width_bits(logic [1:0] code);
    logic [CntW-1:0] n;
    unique case (code)
      WidthCode16: n = CntW'(16);
      WidthCode32: n = CntW'(32);
      default:     n = CntW'(64);
    endcase
    return n;
  endfunction

  // xorshift then rotate, 16-bit variant keeps the short left shift for high rotates
  function automatic logic [63:0] form_xsh_rr(logic [63:0] old, logic [1:0] code);
    logic [63:0]  x;
    logic [4:0]   r;
    logic [127:0] rot64;
    logic [63:0]  rot32;
    logic [15:0]  x16;
    logic [3:0]   l16;
    logic [31:0]  sh16;
    logic [15:0]  right16;
    logic [63:0]  res;
    x       = ((old >> XshShift) ^ old) >> XshDrop;
    r       = 5'(old >> RotPos);
    rot64   = {x, x} >> r;
    rot32   = {x[31:0], x[31:0]} >> r;
    x16     = x[15:0];
    l16     = 4'd0 - r[3:0];
    sh16    = {16'b0, x16} << l16;
    right16 = r[4] ? 16'b0 : (x16 >> r[3:0]);
    unique case (code)
      WidthCode16: res = {48'b0, right16 | sh16[15:0]};
      WidthCode32: res = {32'b0, rot32[31:0]};
      default:     res = rot64[63:0];
    endcase
    return res;
  endfunction

endpackage

### rtl/core/pcg_random_generator_top.sv
// ----------------------------------------------------------------------------
// pcg_random_generator_top
// 64-bit lcg generator with xorshift-rotate output and optional range mapping.
// ----------------------------------------------------------------------------
// Each input transfer is one draw of 16, 32 or 64 bits, formed from the state
// before it advances. The state advance goes through one shared 32x32
// multiplier in three partial products and a final sum, and no new draw is
// accepted until the current one has reached the result register. In range
// mode a bit-serial remainder unit works through each bit of the selected
// width before the result is formed. A seed write (register 0, byte
// address 0) reloads the state through the same multiplier and holds
// s_axis_tready low in the write cycle and through the multiply steps after
// it. The result register lets the next draw be accepted while a result waits
// on the master side.
module pcg_random_generator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcg_pkg::CfgAddrW-1:0] paddr,
  input  logic [pcg_pkg::CfgDataW-1:0] pwdata,
  output logic [pcg_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  // draw requests
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] result_width, [2] use_range, [66:3] range_min, [130:67] range_max,
  // [135:131] zero
  input  logic [135:0]                 s_axis_tdata,
  // drawn values
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [63:0] random_value
  output logic [63:0]                  m_axis_tdata
);
  import pcg_pkg::*;

  pcg_cmd_t    cmd;
  pcg_status_t status;
  logic        cfg_wr;
  logic        reg_hit;
  logic [63:0] seed;

  // register decode, one 64-bit register
  assign reg_hit = (paddr[CfgAddrW-1 -: 1] == RegSeed);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? seed : '0;

  pcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcg_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_wdata_i    (pwdata),
    .seed_o         (seed),
    .result_width_i (s_axis_tdata[1:0]),
    .use_range_i    (s_axis_tdata[2]),
    .range_min_i    (s_axis_tdata[66:3]),
    .range_max_i    (s_axis_tdata[130:67]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .random_value_o (m_axis_tdata)
  );

endmodule

### rtl/core/pcg_ctrl.sv
// ----------------------------------------------------------------------------
// pcg_ctrl
// Sequencer for seed reloads and draws: multiply steps, remainder, output.
// ----------------------------------------------------------------------------
module pcg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcg_pkg::pcg_status_t status_i,
  output pcg_pkg::pcg_cmd_t    cmd_o
);
  import pcg_pkg::*;

  pcg_state_e state_q, state_d;
  logic       draw_q, draw_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      draw_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      draw_q  <= draw_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    draw_d  = draw_q;
    if (cfg_wr_i) begin
      state_d = ST_MUL_LL;
      draw_d  = 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_d = ST_MUL_LL;
            draw_d  = 1'b1;
          end
        end
        ST_MUL_LL: state_d = ST_MUL_LH;
        ST_MUL_LH: state_d = ST_MUL_HL;
        ST_MUL_HL: state_d = ST_MUL_SUM;
        ST_MUL_SUM: begin
          if (!draw_q) begin
            state_d = ST_IDLE;
          end else if (status_i.need_mod) begin
            state_d = ST_MOD;
          end else begin
            state_d = ST_OUT;
          end
        end
        ST_MOD: begin
          if (status_i.mod_done) begin
            state_d = ST_OUT;
          end
        end
        ST_OUT: begin
          if (status_i.out_free) begin
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.seed_op   = !draw_q;
    cmd_o.seed_load = cfg_wr_i;
    cmd_o.mul_step  = MS_LL;
    in_ready_o      = (state_q == ST_IDLE) && !cfg_wr_i;
    cmd_o.item_load = in_ready_o && in_valid_i;
    unique case (state_q)
      ST_MUL_LL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MS_LL;
      end
      ST_MUL_LH: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MS_LH;
        cmd_o.mod_init = 1'b1;
      end
      ST_MUL_HL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MS_HL;
      end
      ST_MUL_SUM: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MS_SUM;
      end
      ST_MOD:  cmd_o.mod_iter = !status_i.mod_done;
      ST_OUT:  cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/pcg_dpath.sv
// ----------------------------------------------------------------------------
// pcg_dpath
// State, shared 32x32 multiplier, output forming, bit-serial remainder and
// output register.
// ----------------------------------------------------------------------------
module pcg_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcg_pkg::pcg_cmd_t              cmd_i,
  output pcg_pkg::pcg_status_t           status_o,
  input  logic [pcg_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output logic [pcg_pkg::CfgDataW-1:0]   seed_o,
  input  logic [1:0]                     result_width_i,
  input  logic                           use_range_i,
  input  logic [63:0]                    range_min_i,
  input  logic [63:0]                    range_max_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [63:0]                    random_value_o
);
  import pcg_pkg::*;

  // control-side registers
  logic [63:0]     state_q;
  logic [63:0]     seed_q;
  logic            out_valid_q;
  logic [CntW-1:0] cnt_q;

  // payload registers
  logic [63:0] mul_a_q;
  logic [63:0] mult_q;
  logic [63:0] prod_q;
  logic [1:0]  width_q;
  logic        use_range_q;
  logic [63:0] lo_q;
  logic [63:0] hi_q;
  logic [63:0] raw_q;
  logic [63:0] span_q;
  logic [63:0] dvd_q;
  logic [63:0] rem_q;
  logic [63:0] out_data_q;

  logic [63:0] mask;
  logic [63:0] mul_b;
  logic [63:0] inc;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mult_d;
  logic [64:0] rem_shift;
  logic [64:0] rem_diff;
  logic [63:0] rem_d;
  logic [63:0] dvd_align;
  logic        need_mod;

  assign mask  = width_mask(width_q);
  assign mul_b = cmd_i.seed_op ? LcgSeedMul : LcgMul;
  assign inc   = cmd_i.seed_op ? 64'd0 : LcgInc;

  // operand halves for the shared multiplier
  always_comb begin
    unique case (cmd_i.mul_step)
      MS_LL: begin
        op_a = mul_a_q[31:0];
        op_b = mul_b[31:0];
      end
      MS_LH: begin
        op_a = mul_a_q[31:0];
        op_b = mul_b[63:32];
      end
      MS_HL: begin
        op_a = mul_a_q[63:32];
        op_b = mul_b[31:0];
      end
      default: begin
        op_a = mul_a_q[31:0];
        op_b = mul_b[31:0];
      end
    endcase
  end

  assign mult_d = {32'b0, op_a} * {32'b0, op_b};

  // one restoring remainder step
  assign rem_shift = {rem_q, dvd_q[63]};
  assign rem_diff  = rem_shift - {1'b0, span_q};
  assign rem_d     = rem_diff[64] ? rem_shift[63:0] : rem_diff[63:0];

  // put the top bit of the selected width at bit 63
  always_comb begin
    unique case (width_q)
      WidthCode16: dvd_align = raw_q << 48;
      WidthCode32: dvd_align = raw_q << 32;
      default:     dvd_align = raw_q;
    endcase
  end

  assign need_mod          = use_range_q && (span_q != 64'd0);
  assign status_o.need_mod = need_mod;
  assign status_o.mod_done = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // state, seed, iteration count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LcgResetState;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.seed_load) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.mul_en && (cmd_i.mul_step == MS_SUM)) begin
        state_q <= prod_q + {mult_q[31:0], 32'b0} + inc;
      end
      if (cmd_i.mod_init) begin
        cnt_q <= width_bits(width_q);
      end else if (cmd_i.mod_iter) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operands, partial products, draw and remainder
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      mul_a_q <= cfg_wdata_i;
    end else if (cmd_i.item_load) begin
      mul_a_q     <= state_q;
      width_q     <= result_width_i;
      use_range_q <= use_range_i;
      lo_q        <= range_min_i & width_mask(result_width_i);
      hi_q        <= range_max_i & width_mask(result_width_i);
    end
    if (cmd_i.mul_en) begin
      mult_q <= mult_d;
      unique case (cmd_i.mul_step)
        MS_LL: begin
          raw_q  <= form_xsh_rr(state_q, width_q);
          span_q <= (hi_q - lo_q + 64'd1) & mask;
        end
        MS_LH:   prod_q <= mult_q;
        MS_HL:   prod_q[63:32] <= prod_q[63:32] + mult_q[31:0];
        default: ;
      endcase
    end
    if (cmd_i.mod_init) begin
      dvd_q <= dvd_align;
      rem_q <= '0;
    end else if (cmd_i.mod_iter) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      out_data_q <= need_mod ? ((rem_q + lo_q) & mask) : raw_q;
    end
  end

  assign seed_o         = seed_q;
  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_data_q;

endmodule

### rtl/core/pcg_random_generator_chk.sv
// ----------------------------------------------------------------------------
// pcg_random_generator_chk
// Port-level checks for the pcg generator, bound to the top level.
// ----------------------------------------------------------------------------
module pcg_random_generator_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [pcg_pkg::CfgAddrW-1:0] paddr,
  input logic                         pready,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [63:0]                  m_axis_tdata
);
  import pcg_pkg::*;

  logic in_xfer;
  logic seed_wr;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign seed_wr = psel && penable && pwrite && pready
                   && (paddr[CfgAddrW-1 -: 1] == RegSeed);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a draw keeps the request side closed while the state advances
  a_busy_after_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("request accepted during state advance");

  // a seed reload keeps the request side closed
  a_busy_after_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_wr |=> !s_axis_tready)
    else $error("request accepted during seed reload");

  // no result can follow the request transfer in the very next cycle
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind pcg_random_generator_top pcg_random_generator_chk u_chk (.*);
